[rtl/core/cfdr_pkg.sv]
// Shared types, constants and functions for the framed date record checker.
package cfdr_pkg;

  localparam int unsigned PosW = 5;

  localparam logic [15:0]     RecordMagic = 16'h4C41;
  localparam logic [7:0]      RecordVer   = 8'd1;
  localparam logic [7:0]      RecordLen   = 8'd16;
  localparam logic [PosW-1:0] PosLen      = 5'd16;
  localparam logic [PosW-1:0] PosCrcEnd   = 5'd12;
  localparam logic [PosW-1:0] PosMax      = 5'd17;

  localparam logic [31:0] CrcPoly = 32'hEDB88320;
  localparam logic [31:0] CrcInit = 32'hFFFFFFFF;

  // Years 2000 to 2099 as a window on the raw YYYYMMDD value.
  localparam logic [31:0] DateLo    = 32'd20000000;
  localparam logic [31:0] DateHi    = 32'd20999999;
  localparam logic [19:0] YyRecip   = 20'd858994;  // ceil(2^33 / 10000)
  localparam int unsigned YyShift   = 33;
  localparam logic [12:0] MmRecip   = 13'd5243;    // ceil(2^19 / 100)
  localparam int unsigned MmShift   = 19;
  localparam logic [19:0] YearStep  = 20'd10000;
  localparam logic [13:0] MonthStep = 14'd100;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_LENGTH  = 3'd1,
    ST_MAGIC   = 3'd2,
    ST_VERSION = 3'd3,
    ST_SIZE    = 3'd4,
    ST_CRC     = 3'd5,
    ST_DATE    = 3'd6
  } status_e;

  typedef struct packed {
    logic        record_ok;
    status_e     status;
    logic [31:0] revision;
    logic [24:0] date_value;
  } result_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    return c;
  endfunction

  function automatic logic [4:0] month_len(input logic [6:0] mm, input logic leap);
    logic [4:0] len;
    unique case (mm)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                    len = 5'd30;
      7'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

[rtl/core/cfdr_date_check.sv]
// Date validity pipeline, stepped by each record byte; the bytes after the date field carry it through.
module cfdr_date_check (
  input  logic        clk_i,
  input  logic        step_i,
  input  logic [31:0] date_i,
  output logic        date_ok_o
);
  import cfdr_pkg::*;

  logic        range_q;
  logic [19:0] r_q;
  logic [6:0]  yy_q;
  logic [13:0] mmdd_q;
  logic [6:0]  mm_q;

  logic [19:0] r_d;
  logic [39:0] yy_prod;
  logic [19:0] mmdd_full;
  logic [26:0] mm_prod;
  logic [13:0] dd_full;
  logic [6:0]  dd;
  logic [4:0]  lim;

  // Offset into the century, then year, month/day remainder, month, day.
  assign r_d       = 20'(date_i - DateLo);
  assign yy_prod   = {20'd0, r_q} * {20'd0, YyRecip};
  assign mmdd_full = r_q - 20'(yy_q) * YearStep;
  assign mm_prod   = {13'd0, mmdd_q} * {14'd0, MmRecip};
  assign dd_full   = mmdd_q - 14'(mm_q) * MonthStep;
  assign dd        = dd_full[6:0];
  assign lim       = month_len(mm_q, yy_q[1:0] == 2'b00);

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      range_q <= (date_i >= DateLo) && (date_i <= DateHi);
      r_q     <= r_d;
      yy_q    <= yy_prod[YyShift +: 7];
      mmdd_q  <= mmdd_full[13:0];
      mm_q    <= mm_prod[MmShift +: 7];
    end
  end

  assign date_ok_o = range_q && (mm_q >= 7'd1) && (mm_q <= 7'd12) &&
                     (dd >= 7'd1) && (dd <= {2'b00, lim});

endmodule

[rtl/core/cfdr_frame.sv]
// Byte capture, running CRC-32 and ordered frame checks.
module cfdr_frame (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [7:0]                data_byte_i,
  input  logic                      last_byte_i,
  input  logic                      date_ok_i,
  output logic [31:0]               date_next_o,
  output cfdr_pkg::result_t         result_o
);
  import cfdr_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic [31:0]     crc_q, crc_d;
  logic [15:0]     magic_q, magic_d;
  logic [7:0]      version_q, version_d;
  logic [7:0]      size_q, size_d;
  logic [31:0]     revision_q, revision_d;
  logic [31:0]     date_q, date_d;
  logic [31:0]     checksum_q, checksum_d;
  status_e         status;

  always_comb begin
    magic_d    = magic_q;
    version_d  = version_q;
    size_d     = size_q;
    revision_d = revision_q;
    date_d     = date_q;
    checksum_d = checksum_q;
    priority if (pos_q < 5'd2) begin
      magic_d[{pos_q[0], 3'b000} +: 8] = data_byte_i;
    end else if (pos_q == 5'd2) begin
      version_d = data_byte_i;
    end else if (pos_q == 5'd3) begin
      size_d = data_byte_i;
    end else if (pos_q < 5'd8) begin
      revision_d[{pos_q[1:0], 3'b000} +: 8] = data_byte_i;
    end else if (pos_q < 5'd12) begin
      date_d[{pos_q[1:0], 3'b000} +: 8] = data_byte_i;
    end else if (pos_q < PosLen) begin
      checksum_d[{pos_q[1:0], 3'b000} +: 8] = data_byte_i;
    end else begin
      // Bytes past the sixteenth are not captured.
      checksum_d = checksum_q;
    end
    crc_d = (pos_q < PosCrcEnd) ? crc_byte(crc_q, data_byte_i) : crc_q;
    pos_d = (pos_q < PosMax) ? pos_q + 5'd1 : pos_q;
  end

  always_comb begin
    priority if (pos_d != PosLen) begin
      status = ST_LENGTH;
    end else if (magic_d != RecordMagic) begin
      status = ST_MAGIC;
    end else if (version_d != RecordVer) begin
      status = ST_VERSION;
    end else if (size_d != RecordLen) begin
      status = ST_SIZE;
    end else if (checksum_d != ~crc_d) begin
      status = ST_CRC;
    end else if (!date_ok_i) begin
      status = ST_DATE;
    end else begin
      status = ST_OK;
    end
  end

  assign date_next_o          = date_d;
  assign result_o.record_ok   = (status == ST_OK);
  assign result_o.status      = status;
  assign result_o.revision    = (status == ST_OK) ? revision_d : 32'd0;
  assign result_o.date_value  = (status == ST_OK) ? date_d[24:0] : 25'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      crc_q      <= CrcInit;
      magic_q    <= '0;
      version_q  <= '0;
      size_q     <= '0;
      revision_q <= '0;
      date_q     <= '0;
      checksum_q <= '0;
    end else if (step_i) begin
      if (last_byte_i) begin
        pos_q      <= '0;
        crc_q      <= CrcInit;
        magic_q    <= '0;
        version_q  <= '0;
        size_q     <= '0;
        revision_q <= '0;
        date_q     <= '0;
        checksum_q <= '0;
      end else begin
        pos_q      <= pos_d;
        crc_q      <= crc_d;
        magic_q    <= magic_d;
        version_q  <= version_d;
        size_q     <= size_d;
        revision_q <= revision_d;
        date_q     <= date_d;
        checksum_q <= checksum_d;
      end
    end
  end

endmodule

[rtl/core/crc_framed_date_record_decoder.sv]
// Top level of the framed date record checker: channel registers and assertions.
//
// Input channel: one record byte per transfer (data_byte_i) with last_byte_i
// marking the final byte of a record. Output channel: one result per record,
// given on the transfer that carries last_byte_i: record_ok_o, status_o and,
// on success only, revision_o and date_value_o (both zero on failure).
// A well-formed record is 16 bytes: magic, version, size, revision, date,
// and a CRC-32 of the first 12 bytes.
// Throughput: one byte per cycle while out_stall_i holds no result, set by
// the byte-wide CRC update and the single processing stage between the
// input and result registers, which hold a final byte and then its result.
// The date check runs as a short multiply pipeline that advances with the
// checksum bytes, so it is finished when the final byte is processed.
// Reset clears the frame's record state; the next byte starts a new record. After
// each result the record state returns to its reset value as well.
// When out_stall_i holds a waiting result, one more byte can sit in the input
// register; in_stall_o then rises until the result is taken.
module crc_framed_date_record_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        record_ok_o,
  output logic [2:0]  status_o,
  output logic [31:0] revision_o,
  output logic [24:0] date_value_o
);
  import cfdr_pkg::*;

  logic        in_valid_q;
  logic [7:0]  data_q;
  logic        last_q;
  logic        out_valid_q;
  result_t     res_q;
  result_t     res;
  logic        advance;
  logic        step;
  logic        date_ok;
  logic [31:0] date_next;

  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= step && last_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      data_q <= data_byte_i;
      last_q <= last_byte_i;
    end
    if (step && last_q) begin
      res_q <= res;
    end
  end

  cfdr_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (data_q),
    .last_byte_i (last_q),
    .date_ok_i   (date_ok),
    .date_next_o (date_next),
    .result_o    (res)
  );

  cfdr_date_check u_date (
    .clk_i     (clk_i),
    .step_i    (step),
    .date_i    (date_next),
    .date_ok_o (date_ok)
  );

  assign out_valid_o  = out_valid_q;
  assign record_ok_o  = res_q.record_ok;
  assign status_o     = res_q.status;
  assign revision_o   = res_q.revision;
  assign date_value_o = res_q.date_value;

`ifndef SYNTHESIS
  a_ok_matches_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.record_ok == (res_q.status == ST_OK)))
    else $error("record_ok disagrees with status");

  a_fail_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.record_ok) |-> (res_q.revision == 32'd0 &&
                                            res_q.date_value == 25'd0))
    else $error("failed record carries decoded fields");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q && last_q))
    else $error("result without a final byte");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_q && out_stall_i && in_valid_q))
    else $error("input stalled without a blocked result");
`endif

endmodule
